/* sv/etc_pkg.sv */
// shared types and constants for the enclosure thermal controller
package etc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_HYSTERESIS    = 3'd1,
    REG_LIMIT_HIGH    = 3'd2,
    REG_LIMIT_LOW     = 3'd3,
    REG_BOOST_PERIOD  = 3'd4,
    REG_BOOST_LENGTH  = 3'd5,
    REG_HEAT_MIN_PCT  = 3'd6,
    REG_BOOST_PCT     = 3'd7
  } cfg_idx_e;

  localparam logic [10:0]        RST_SETPOINT     = 11'd640;
  localparam logic [6:0]         RST_HYSTERESIS   = 7'd5;
  localparam logic signed [11:0] RST_LIMIT_HIGH   = 12'sd1840;
  localparam logic signed [11:0] RST_LIMIT_LOW    = 12'sd1760;
  localparam logic [31:0]        RST_BOOST_PERIOD = 32'd120000;
  localparam logic [31:0]        RST_BOOST_LENGTH = 32'd15000;
  localparam logic [6:0]         RST_HEAT_MIN_PCT = 7'd40;
  localparam logic [6:0]         RST_BOOST_PCT    = 7'd50;

  localparam logic [7:0] INTAKE_STEP  = 8'd7;
  localparam logic [7:0] EXHAUST_STEP = 8'd8;
  localparam logic [7:0] PCT_MAX      = 8'd100;

  typedef struct packed {
    logic [10:0]        setpoint;
    logic [6:0]         hysteresis;
    logic signed [11:0] limit_high;
    logic signed [11:0] limit_low;
    logic [31:0]        boost_period;
    logic [31:0]        boost_length;
    logic [6:0]         heat_min_pct;
    logic [6:0]         boost_pct;
  } cfg_t;

  typedef struct packed {
    logic        heating;
    logic        limit;
    logic        boost;
    logic [31:0] last_boost;
    logic [31:0] boost_start;
    logic [6:0]  intake;
    logic [6:0]  exhaust;
  } state_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [11:0] box_temp;
    logic signed [11:0] heater_temp;
  } item_t;

  typedef struct packed {
    logic       boost_flag;
    logic       limit_flag;
    logic [6:0] exhaust_fan_pct;
    logic [6:0] intake_fan_pct;
    logic       heater_drive;
  } res_t;

endpackage

/* sv/enclosure_thermal_controller_top.sv */
// enclosure thermal controller top level: input register, tick logic, result register
//
// One control tick per input transaction on the s_axis channel: heater
// temperature, box temperature and millisecond time. Each tick yields exactly
// one result transaction on m_axis: heater drive, both fan duties after
// ramping, lockout flag and boost flag.
// An accepted tick is registered in the input register, worked through the tick
// logic and captured in the result register, which drives m_axis.
// One tick is accepted every cycle while m_axis does not stall, set by the
// combinational compare-and-add path between the input and result registers.
// When m_axis stalls the result holds and one more tick waits in the input
// register; s_axis_tready drops only when both are full.
// Configuration writes through cfg_we_i/cfg_index_i/cfg_data_i take effect at
// the next edge; the user must make them while no tick is in flight (unchecked).
// Reset clears the controller state (heater off, no lockout, no boost, fans
// at 0, boost timestamps at 0), reloads register defaults and empties both
// registers.
module enclosure_thermal_controller_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [etc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [etc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // heater_temp [11:0], box_temp [23:12], now_ms [55:24]
  input  logic [etc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // heater_drive [0], intake_fan_pct [7:1], exhaust_fan_pct [14:8],
  // limit_flag [15], boost_flag [16], zero [23:17]
  output logic [etc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import etc_pkg::*;

  cfg_t   cfg;
  state_t st_q, st_d;
  res_t   res_d, res_q;
  item_t  in_q;
  logic   in_valid_q, in_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   adv;
  logic   s_acc;

  etc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  etc_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  assign in_valid_d  = s_acc | (in_valid_q & ~adv);
  assign out_valid_d = adv | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q <= item_t'(s_axis_tdata);
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res_q};

  a_limit_blocks_heat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.limit |-> !st_q.heating)
    else $error("heating while lockout active");

  a_boost_needs_heat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.boost |-> st_q.heating)
    else $error("boost running without heating");

  a_fan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.intake <= 7'd100) && (st_q.exhaust <= 7'd100))
    else $error("fan level above 100 percent");

  a_result_from_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv))
    else $error("result appeared without a processed tick");

endmodule

/* sv/etc_cfg.sv */
// configuration register file
module etc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [etc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [etc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output etc_pkg::cfg_t                 cfg_o
);
  import etc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_SETPOINT:     cfg_d.setpoint     = cfg_data_i[10:0];
        REG_HYSTERESIS:   cfg_d.hysteresis   = cfg_data_i[6:0];
        REG_LIMIT_HIGH:   cfg_d.limit_high   = $signed(cfg_data_i[11:0]);
        REG_LIMIT_LOW:    cfg_d.limit_low    = $signed(cfg_data_i[11:0]);
        REG_BOOST_PERIOD: cfg_d.boost_period = cfg_data_i;
        REG_BOOST_LENGTH: cfg_d.boost_length = cfg_data_i;
        REG_HEAT_MIN_PCT: cfg_d.heat_min_pct = cfg_data_i[6:0];
        REG_BOOST_PCT:    cfg_d.boost_pct    = cfg_data_i[6:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint     <= RST_SETPOINT;
      cfg_q.hysteresis   <= RST_HYSTERESIS;
      cfg_q.limit_high   <= RST_LIMIT_HIGH;
      cfg_q.limit_low    <= RST_LIMIT_LOW;
      cfg_q.boost_period <= RST_BOOST_PERIOD;
      cfg_q.boost_length <= RST_BOOST_LENGTH;
      cfg_q.heat_min_pct <= RST_HEAT_MIN_PCT;
      cfg_q.boost_pct    <= RST_BOOST_PCT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/etc_step.sv */
// one control tick: lockout, thermostat, boost timer, fan curves and ramps
module etc_step (
  input  etc_pkg::cfg_t   cfg_i,
  input  etc_pkg::state_t st_i,
  input  etc_pkg::item_t  item_i,
  output etc_pkg::state_t st_o,
  output etc_pkg::res_t   res_o
);
  import etc_pkg::*;

  function automatic logic [6:0] ramp(input logic [6:0] cur, input logic [6:0] tgt,
                                      input logic [7:0] step);
    logic [7:0] c;
    logic [7:0] t;
    logic [7:0] d;
    logic [7:0] r;
    c = {1'b0, cur};
    t = {1'b0, tgt};
    r = c;
    if (t > c) begin
      d = t - c;
      r = c + ((d < step) ? d : step);
    end else if (t < c) begin
      d = c - t;
      r = c - ((d < step) ? d : step);
    end
    if (r > PCT_MAX) begin
      r = PCT_MAX;
    end
    return r[6:0];
  endfunction

  logic               lim_set;
  logic               lim_n;
  logic               heat_n;
  logic               boost_n;
  logic signed [13:0] box_s;
  logic signed [13:0] sp_s;
  logic signed [13:0] hy_s;
  logic signed [13:0] over;
  logic [31:0]        since_last;
  logic [31:0]        since_start;
  logic [5:0]         oc;
  logic [8:0]         oc10;
  logic [4:0]         in_ext;
  logic [6:0]         in_curve;
  logic [6:0]         in_tgt;
  logic [5:0]         oe;
  logic [9:0]         ex_prod;
  logic [6:0]         ex_tgt;

  assign box_s = 14'(item_i.box_temp);
  assign sp_s  = $signed({3'b000, cfg_i.setpoint});
  assign hy_s  = $signed({7'b0000000, cfg_i.hysteresis});
  assign over  = box_s - sp_s;

  // lockout set test then clear test
  assign lim_set = st_i.limit | ($signed(item_i.heater_temp) > $signed(cfg_i.limit_high));
  assign lim_n   = lim_set & ~($signed(item_i.heater_temp) < $signed(cfg_i.limit_low));

  always_comb begin
    if (lim_n) begin
      heat_n = 1'b0;
    end else if (!st_i.heating) begin
      heat_n = (box_s <= (sp_s - hy_s));
    end else begin
      heat_n = !(box_s >= (sp_s + hy_s));
    end
  end

  assign since_last  = item_i.now_ms - st_i.last_boost;
  assign since_start = item_i.now_ms - st_i.boost_start;

  // cooling curve for intake, saturates at 50 once over reaches 36
  assign oc       = (over > 14'sd40) ? 6'd40 : over[5:0];
  assign oc10     = 9'({3'b000, oc} * 9'd10) - 9'd32;
  assign in_ext   = oc10[8:4];
  assign in_curve = (7'd30 + {2'b00, in_ext} > 7'd50) ? 7'd50 : 7'd30 + {2'b00, in_ext};

  assign oe      = (over > 14'sd48) ? 6'd48 : over[5:0];
  assign ex_prod = 10'({4'b0000, oe - 6'd8} * 10'd18) + 10'd8;
  assign ex_tgt  = (over > 14'sd8) ? 7'd25 + {1'b0, ex_prod[9:4]} : 7'd0;

  always_comb begin
    st_o.last_boost  = st_i.last_boost;
    st_o.boost_start = st_i.boost_start;
    boost_n          = st_i.boost;
    if (heat_n) begin
      if (!st_i.boost) begin
        if (since_last >= cfg_i.boost_period) begin
          boost_n          = 1'b1;
          st_o.boost_start = item_i.now_ms;
          st_o.last_boost  = item_i.now_ms;
        end
      end else if (since_start >= cfg_i.boost_length) begin
        boost_n = 1'b0;
      end
      in_tgt = boost_n ? cfg_i.boost_pct : cfg_i.heat_min_pct;
    end else begin
      in_tgt  = (over > 14'sd3) ? in_curve : 7'd0;
      boost_n = 1'b0;
    end
    st_o.heating = heat_n;
    st_o.limit   = lim_n;
    st_o.boost   = boost_n;
    st_o.intake  = ramp(st_i.intake, in_tgt, INTAKE_STEP);
    st_o.exhaust = ramp(st_i.exhaust, ex_tgt, EXHAUST_STEP);
  end

  assign res_o.heater_drive    = heat_n;
  assign res_o.intake_fan_pct  = st_o.intake;
  assign res_o.exhaust_fan_pct = st_o.exhaust;
  assign res_o.limit_flag      = lim_n;
  assign res_o.boost_flag      = boost_n;

endmodule
